// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the joint velocity PID block.
// Active in simulation; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define JVP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define JVP_ASSERT(lbl, prop)
`define JVP_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== src/jvp_pkg.sv =====
// Types and constants of the joint velocity PID torque limiter.
// No dependencies; used by the top level and the serial arithmetic units.
`default_nettype none

package jvp_pkg;

  localparam int DATA_W = 32;
  localparam int GAIN_W = 31;
  localparam int PER_W  = 17;
  localparam int IFRAC_W = 16;
  localparam int ADDR_W = 5;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_ILIM   = 3'd4,
    REG_ELIM   = 3'd5,
    REG_IFRAC  = 3'd6,
    REG_FSCALE = 3'd7
  } reg_idx_e;

  // product currently held by the shared serial multiplier
  typedef enum logic [2:0] {
    OP_P   = 3'd0,
    OP_I1  = 3'd1,
    OP_I2  = 3'd2,
    OP_D   = 3'd3,
    OP_THR = 3'd4,
    OP_FR  = 3'd5,
    OP_POS = 3'd6
  } op_e;

  // sequencer, one-hot
  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_ERR     = 13'b0000000000010,
    S_DIFF    = 13'b0000000000100,
    S_MLAUNCH = 13'b0000000001000,
    S_MWAIT   = 13'b0000000010000,
    S_DLAUNCH = 13'b0000000100000,
    S_DWAIT   = 13'b0000001000000,
    S_INTEG   = 13'b0000010000000,
    S_PIDSUM  = 13'b0000100000000,
    S_CLAMP   = 13'b0001000000000,
    S_CMD     = 13'b0010000000000,
    S_POSADD  = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_e;

endpackage

`default_nettype wire

// ===== src/jvp_mul.sv =====
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// Uses jvp_pkg for the operand width.
`default_nettype none

module jvp_mul
  import jvp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DATA_W-1:0]     a_i,
  input  wire logic [DATA_W-1:0]     b_i,
  output logic                       done_o,
  output logic [2*DATA_W-1:0]        prod_o
);

  localparam int CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] mcand_q;
  logic [DATA_W:0]   hi_q, hi_d;
  logic [DATA_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic              last;
  logic signed [DATA_W:0]   addend;
  logic signed [DATA_W+1:0] sum;

  assign last = (cnt_q == CNT_W'(DATA_W-1));

  // add (or subtract on the sign bit) the multiplicand, then shift right
  always_comb begin
    addend = '0;
    if (lo_q[0]) begin
      addend = last ? -$signed({mcand_q[DATA_W-1], mcand_q})
                    : $signed({mcand_q[DATA_W-1], mcand_q});
    end
    sum  = $signed({hi_q[DATA_W], hi_q}) + (DATA_W+2)'(addend);
    hi_d = sum[DATA_W+1:1];
    lo_d = {sum[0], lo_q[DATA_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i;
      hi_q    <= '0;
      lo_q    <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[DATA_W-1:0], lo_q};

endmodule

`default_nettype wire

// ===== src/jvp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Unsigned dividend of DIVIDEND_W bits by a 17-bit divisor; uses jvp_pkg.
`default_nettype none

module jvp_div
  import jvp_pkg::*;
#(
  parameter int DIVIDEND_W = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [PER_W-1:0]      divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] dq_q;
  logic [PER_W-1:0]      div_q, rem_q, rem_d;
  logic [PER_W:0]        rs;
  logic                  ge;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic                  last;

  assign last = (cnt_q == CNT_W'(DIVIDEND_W-1));

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    rs    = {rem_q, dq_q[DIVIDEND_W-1]};
    ge    = (rs >= {1'b0, div_q});
    rem_d = ge ? PER_W'(rs - {1'b0, div_q}) : rs[PER_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIVIDEND_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

`default_nettype wire

// ===== src/joint_velocity_pid_torque_limiter_top.sv =====
// Top level of the joint velocity PID torque limiter: APB registers,
// sequencer and datapath. Uses jvp_pkg, jvp_mul, jvp_div, assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i/in_ready_o  | velocity_target_i .. impedance_torque_i
//  out     | output    | out_valid_o/out_ready_i| joint_command_o, flags
//  cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata
//
// Torque mode: six serial multiplies (launch, serial steps, done), one serial
// divide and the sequencing states accept, error, diff, integ, sum, clamp, cmd
// and out.
// Position mode: one multiply and the states accept, error, posadd and out.
// One transaction at a time; the output register lets the next input be taken
// while a result waits. Reset sets config defaults and clears the PID state.
`default_nettype none
`include "assert_macros.svh"

module joint_velocity_pid_torque_limiter_top
  import jvp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [DATA_W-1:0]   velocity_target_i,
  input  wire logic [DATA_W-1:0]   measured_velocity_i,
  input  wire logic [DATA_W-1:0]   measured_position_i,
  input  wire logic [PER_W-1:0]    tick_period_i,
  input  wire logic [DATA_W-1:0]   gravity_torque_i,
  input  wire logic [DATA_W-1:0]   friction_torque_i,
  input  wire logic [DATA_W-1:0]   impedance_torque_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [DATA_W-1:0]        joint_command_o,
  output logic                     pid_over_limit_o,
  output logic                     impedance_clamped_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int DIV_W = DATA_W + FRAC_BITS;
  localparam int FR_W  = 2*DATA_W - FRAC_BITS;
  localparam int CMD_W = FR_W + 2;
  localparam int VEL_LIM_I = ((1 << FRAC_BITS)*2 + 5) / 10;
  localparam logic signed [DATA_W-1:0] VEL_LIM = DATA_W'(VEL_LIM_I);
  localparam logic signed [2*DATA_W-1:0] S32_MAX64 = 64'sd2147483647;
  localparam logic signed [2*DATA_W-1:0] S32_MIN64 = -64'sd2147483648;
  localparam logic [DATA_W-1:0] S32_MAX = 32'h7fffffff;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h80000000;

  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] x);
    logic [DATA_W-1:0] r;
    if (x[DATA_W] != x[DATA_W-1]) r = x[DATA_W] ? S32_MIN : S32_MAX;
    else r = x[DATA_W-1:0];
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  logic                 mode_q;
  logic [GAIN_W-1:0]    kp_q, ki_q, kd_q, ilim_q, elim_q;
  logic [IFRAC_W-1:0]   ifrac_q;
  logic [DATA_W-1:0]    fscale_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      ilim_q   <= '0;
      elim_q   <= '0;
      ifrac_q  <= IFRAC_W'(5243);
      fscale_q <= DATA_W'(65536);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:   mode_q   <= pwdata[0];
        REG_KP:     kp_q     <= pwdata[GAIN_W-1:0];
        REG_KI:     ki_q     <= pwdata[GAIN_W-1:0];
        REG_KD:     kd_q     <= pwdata[GAIN_W-1:0];
        REG_ILIM:   ilim_q   <= pwdata[GAIN_W-1:0];
        REG_ELIM:   elim_q   <= pwdata[GAIN_W-1:0];
        REG_IFRAC:  ifrac_q  <= pwdata[IFRAC_W-1:0];
        REG_FSCALE: fscale_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:   prdata = {31'b0, mode_q};
      REG_KP:     prdata = {1'b0, kp_q};
      REG_KI:     prdata = {1'b0, ki_q};
      REG_KD:     prdata = {1'b0, kd_q};
      REG_ILIM:   prdata = {1'b0, ilim_q};
      REG_ELIM:   prdata = {1'b0, elim_q};
      REG_IFRAC:  prdata = {16'b0, ifrac_q};
      REG_FSCALE: prdata = fscale_q;
      default:    prdata = '0;
    endcase
  end

  // ---------------- sequencer and datapath registers ----------------
  state_e state_q;
  op_e    op_q;
  logic   in_acc;

  logic signed [DATA_W-1:0] tgt_q, mvel_q, mpos_q, grav_q, fric_q, imp_q;
  logic [PER_W-1:0]         per_q;
  logic signed [DATA_W-1:0] err_q, diff_q, p_q, t1_q, inc_q, d0_q, d_q;
  logic signed [DATA_W-1:0] isum_q, prev_q;
  logic [GAIN_W-1:0]        thr_q;
  logic signed [FR_W-1:0]   fr_q;
  logic signed [DATA_W+1:0] pid_q;
  logic                     over_q, clamp_q;
  logic [DATA_W-1:0]        res_q;
  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_cmd_q;
  logic                     out_over_q, out_clamp_q;
  logic                     out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  // result moves into the output register when it is empty or being drained
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // ---------------- serial units ----------------
  logic                  mul_start, mul_done;
  logic [DATA_W-1:0]     mul_a, mul_b;
  logic [2*DATA_W-1:0]   mul_prod;
  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_dividend, div_quot;
  logic [DATA_W-1:0]     d0_abs;

  assign mul_start = (state_q == S_MLAUNCH);
  assign div_start = (state_q == S_DLAUNCH);

  // multiplier operands per product
  always_comb begin
    unique case (op_q)
      OP_P:    begin mul_a = {1'b0, kp_q}; mul_b = err_q; end
      OP_I1:   begin mul_a = {1'b0, ki_q}; mul_b = err_q; end
      OP_I2:   begin mul_a = t1_q;         mul_b = {15'b0, per_q}; end
      OP_D:    begin mul_a = {1'b0, kd_q}; mul_b = diff_q; end
      OP_THR:  begin mul_a = {1'b0, elim_q}; mul_b = {16'b0, ifrac_q}; end
      OP_FR:   begin mul_a = fscale_q;     mul_b = fric_q; end
      OP_POS:  begin mul_a = err_q;        mul_b = {15'b0, per_q}; end
      default: begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  jvp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign d0_abs       = d0_q[DATA_W-1] ? DATA_W'(-d0_q) : d0_q;
  assign div_dividend = {d0_abs, {FRAC_BITS{1'b0}}};

  jvp_div #(
    .DIVIDEND_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (per_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------- combinational helpers ----------------
  logic signed [2*DATA_W-1:0] prod_sh, pos_sum;
  logic [DATA_W-1:0]          res32, pos_res, d_sat, err_d, diff_d, v_clamp;
  logic signed [DATA_W+1:0]   isum_s, ilim_w, pid_s, apid, aimp, pid_c;
  logic                       over_d, clamp_d;
  logic signed [CMD_W-1:0]    cmd_s, el_w;
  logic [DATA_W-1:0]          cmd_res;

  assign prod_sh = $signed(mul_prod) >>> FRAC_BITS;

  // product scaled back and saturated to 32 bits
  always_comb begin
    if (prod_sh > S32_MAX64)      res32 = S32_MAX;
    else if (prod_sh < S32_MIN64) res32 = S32_MIN;
    else                          res32 = prod_sh[DATA_W-1:0];
  end

  assign err_d  = sat33($signed({tgt_q[DATA_W-1], tgt_q}) - $signed({mvel_q[DATA_W-1], mvel_q}));
  assign diff_d = sat33($signed({err_q[DATA_W-1], err_q}) - $signed({prev_q[DATA_W-1], prev_q}));

  // position mode velocity clamp
  always_comb begin
    if (tgt_q < -VEL_LIM)     v_clamp = -VEL_LIM;
    else if (tgt_q > VEL_LIM) v_clamp = VEL_LIM;
    else                      v_clamp = tgt_q;
  end

  // quotient: sign restored, saturated
  always_comb begin
    if (d0_q[DATA_W-1]) begin
      if (div_quot > DIV_W'(33'h080000000)) d_sat = S32_MIN;
      else d_sat = DATA_W'(-div_quot[DATA_W-1:0]);
    end else begin
      if (div_quot > DIV_W'(S32_MAX)) d_sat = S32_MAX;
      else d_sat = div_quot[DATA_W-1:0];
    end
  end

  // integral update with anti-windup clamp
  always_comb begin
    ilim_w = $signed({3'b0, ilim_q});
    isum_s = (DATA_W+2)'(isum_q) + (DATA_W+2)'(inc_q);
    if (isum_s >= ilim_w) isum_s = ilim_w;
    if (isum_s <= -ilim_w) isum_s = -ilim_w;
  end

  assign pid_s = (DATA_W+2)'(p_q) + (DATA_W+2)'(d_q) + (DATA_W+2)'(isum_q);

  // over-limit flag and impedance clamp
  always_comb begin
    apid    = pid_q[DATA_W+1] ? -pid_q : pid_q;
    aimp    = imp_q[DATA_W-1] ? -(DATA_W+2)'(imp_q) : (DATA_W+2)'(imp_q);
    over_d  = apid > $signed({3'b0, elim_q});
    clamp_d = (aimp > $signed({3'b0, thr_q})) && (apid > aimp);
    pid_c   = pid_q;
    if (clamp_d) pid_c = (pid_q > 0) ? aimp : -aimp;
  end

  // feedforward sum and effort saturation
  always_comb begin
    el_w  = $signed({{(CMD_W-GAIN_W){1'b0}}, elim_q});
    cmd_s = CMD_W'(grav_q) + CMD_W'(pid_q) + CMD_W'(fr_q);
    if (cmd_s > el_w)       cmd_res = el_w[DATA_W-1:0];
    else if (cmd_s < -el_w) cmd_res = DATA_W'(-el_w);
    else                    cmd_res = cmd_s[DATA_W-1:0];
  end

  assign pos_sum = (2*DATA_W)'(mpos_q) + prod_sh;
  always_comb begin
    if (pos_sum > S32_MAX64)      pos_res = S32_MAX;
    else if (pos_sum < S32_MIN64) pos_res = S32_MIN;
    else                          pos_res = pos_sum[DATA_W-1:0];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_P;
      isum_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) state_q <= S_ERR;
        S_ERR: begin
          if (mode_q) begin
            op_q    <= OP_POS;
            state_q <= S_MLAUNCH;
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          op_q    <= OP_P;
          state_q <= S_MLAUNCH;
        end
        S_MLAUNCH: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            unique case (op_q)
              OP_P:   begin op_q <= OP_I1;  state_q <= S_MLAUNCH; end
              OP_I1:  begin op_q <= OP_I2;  state_q <= S_MLAUNCH; end
              OP_I2:  begin op_q <= OP_D;   state_q <= S_MLAUNCH; end
              OP_D:   state_q <= S_DLAUNCH;
              OP_THR: begin op_q <= OP_FR;  state_q <= S_MLAUNCH; end
              OP_FR:  state_q <= S_INTEG;
              OP_POS: state_q <= S_POSADD;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DLAUNCH: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            op_q    <= OP_THR;
            state_q <= S_MLAUNCH;
          end
        end
        S_INTEG: begin
          isum_q  <= isum_s[DATA_W-1:0];
          prev_q  <= err_q;
          state_q <= S_PIDSUM;
        end
        S_PIDSUM: state_q <= S_CLAMP;
        S_CLAMP:  state_q <= S_CMD;
        S_CMD:    state_q <= S_OUT;
        S_POSADD: state_q <= S_OUT;
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q  <= velocity_target_i;
      mvel_q <= measured_velocity_i;
      mpos_q <= measured_position_i;
      per_q  <= (tick_period_i == '0) ? PER_W'(1) : tick_period_i;
      grav_q <= gravity_torque_i;
      fric_q <= friction_torque_i;
      imp_q  <= impedance_torque_i;
    end
    if (state_q == S_ERR) begin
      err_q   <= mode_q ? v_clamp : err_d;
      over_q  <= 1'b0;
      clamp_q <= 1'b0;
    end
    if (state_q == S_DIFF) diff_q <= diff_d;
    if (state_q == S_MWAIT && mul_done) begin
      case (op_q)
        OP_P:   p_q   <= res32;
        OP_I1:  t1_q  <= res32;
        OP_I2:  inc_q <= res32;
        OP_D:   d0_q  <= res32;
        OP_THR: thr_q <= mul_prod[GAIN_W+15:16];
        OP_FR:  fr_q  <= prod_sh[FR_W-1:0];
        default: ;
      endcase
    end
    if (state_q == S_DWAIT && div_done) d_q <= d_sat;
    if (state_q == S_PIDSUM) pid_q <= pid_s;
    if (state_q == S_CLAMP) begin
      pid_q   <= pid_c;
      over_q  <= over_d;
      clamp_q <= clamp_d;
    end
    if (state_q == S_CMD)    res_q <= cmd_res;
    if (state_q == S_POSADD) res_q <= pos_res;
    if (out_load) begin
      out_cmd_q   <= res_q;
      out_over_q  <= over_q;
      out_clamp_q <= clamp_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign joint_command_o     = out_cmd_q;
  assign pid_over_limit_o    = out_over_q;
  assign impedance_clamped_o = out_clamp_q;

  // ---------------- assertions ----------------
  `JVP_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o)
  `JVP_ASSERT(a_mul_done_waited, mul_done |-> state_q == S_MWAIT)
  `JVP_ASSERT(a_div_done_waited, div_done |-> state_q == S_DWAIT)
  `JVP_ASSERT(a_out_held, out_valid_o && !out_ready_i |=> out_valid_o && $stable(joint_command_o))

endmodule

`default_nettype wire
